[design/lfu_pkg.sv]
// Shared types and constants for the LFU cache table.
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 16;
	localparam int STAMP_W = 32;
	localparam int CFG_W   = 5;

	localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
	localparam logic [STAMP_W-1:0] TICK_MAX  = '1;
	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);

	typedef logic [CNT_W-1:0]   count_t;
	typedef logic [STAMP_W-1:0] stamp_t;

	// one memory word per slot
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		count_t           count;
		stamp_t           stamp;
	} entry_t;

endpackage

[design/lfu_cache_table_unit.sv]
// LFU cache table with LRU tiebreak: scan sequencer over an entry memory with a single read port.
// Sequence: after start is accepted, SCAN reads every slot, LAST evaluates the final word
//   and UPDATE writes the entry and posts the result (zero capacity answers from idle).
//   A new item is taken only when idle, as the single read port is scanned one slot per cycle.
// Reset (arst_n low, asynchronous): all entries invalid, occupancy and tick zero,
//   capacity register 16, sequencer idle. The receiver cannot stall: done is a pulse.
module lfu_cache_table_unit
	import lfu_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [KEY_W-1:0]   lookup_key,
	input  logic [VAL_W-1:0]   write_value,
	// capacity register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	// result, one cycle per word
	output logic               done,
	output logic               hit,
	output logic [VAL_W-1:0]   read_value
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CAP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	// IDLE waits for start; SCAN issues one read per slot; LAST evaluates the
	// final read word; UPDATE writes the touched/inserted slot and posts the result.
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST, ST_UPDATE} state_t;

	state_t state_q;

	// entry memory, registered read
	entry_t mem [CAPACITY];
	entry_t rdata_s1;
	logic   mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t mem_wdata;

	// per-slot valid bits live in flops so reset clears them at once
	logic [CAPACITY-1:0] valid_q;
	logic [OCC_W-1:0]    occ_q;
	stamp_t              tick_q;
	logic [CFG_W-1:0]    cfg_q;

	logic [IDX_W-1:0] cnt_q;
	logic             val_s1;
	logic [IDX_W-1:0] idx_s1;

	// latched request
	logic             act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] wval_q;

	// scan trackers
	logic             found_q, have_min_q, have_free_q;
	logic [IDX_W-1:0] match_idx_q, min_idx_q, free_idx_q;
	logic [VAL_W-1:0] match_val_q;
	count_t           match_cnt_q, min_cnt_q;
	stamp_t           min_stamp_q;

	logic accept;
	logic [CAP_W-1:0] cap_eff, cfg_ext, cap_lim, occ_ext;
	logic full;
	logic use_victim, do_insert;
	logic slot_valid, key_match, min_better;
	stamp_t tick_nx;
	count_t cnt_nx;
	logic [IDX_W-1:0] ins_slot;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// effective capacity is the register clamped to CAPACITY
	assign cfg_ext = CAP_W'(cfg_q);
	assign cap_lim = CAP_W'(CAPACITY);
	assign cap_eff = (cfg_ext > cap_lim) ? cap_lim : cfg_ext;
	assign occ_ext = CAP_W'(occ_q);
	assign full    = (occ_ext >= cap_eff);

	// compare of the word coming back from memory
	assign slot_valid = val_s1 && valid_q[idx_s1];
	assign key_match  = slot_valid && (rdata_s1.key == key_q);
	// strict less keeps the lowest slot on a full tie
	assign min_better = slot_valid && (!have_min_q ||
		(rdata_s1.count < min_cnt_q) ||
		((rdata_s1.count == min_cnt_q) && (rdata_s1.stamp < min_stamp_q)));

	// saturating tick and use count
	assign tick_nx = (tick_q != TICK_MAX) ? tick_q + STAMP_W'(1) : tick_q;
	assign cnt_nx  = (match_cnt_q != COUNT_MAX) ? match_cnt_q + CNT_W'(1) : match_cnt_q;

	// a put of a new key replaces the victim when full, else takes the lowest free slot
	assign use_victim = full && have_min_q;
	assign do_insert  = act_q && !found_q && (use_victim || have_free_q);
	assign ins_slot   = use_victim ? min_idx_q : free_idx_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = match_idx_q;
		mem_wdata = '{key: key_q, value: match_val_q, count: cnt_nx, stamp: tick_nx};
		if (state_q == ST_UPDATE) begin
			if (found_q) begin
				mem_we = 1'b1;
				if (act_q) begin
					mem_wdata.value = wval_q;
				end
			end else if (do_insert) begin
				mem_we    = 1'b1;
				mem_waddr = ins_slot;
				mem_wdata = '{key: key_q, value: wval_q, count: CNT_W'(1), stamp: tick_nx};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[cnt_q];
	end

	// request latch and scan payload trackers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			key_q  <= lookup_key;
			wval_q <= write_value;
		end
		idx_s1 <= cnt_q;
		if (key_match && !found_q) begin
			match_idx_q <= idx_s1;
			match_val_q <= rdata_s1.value;
			match_cnt_q <= rdata_s1.count;
		end
		if (min_better) begin
			min_idx_q   <= idx_s1;
			min_cnt_q   <= rdata_s1.count;
			min_stamp_q <= rdata_s1.stamp;
		end
		if (val_s1 && !valid_q[idx_s1] && !have_free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// sequencer, flags, cache bookkeeping and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			val_s1      <= 1'b0;
			found_q     <= 1'b0;
			have_min_q  <= 1'b0;
			have_free_q <= 1'b0;
			valid_q     <= '0;
			occ_q       <= '0;
			tick_q      <= '0;
			cfg_q       <= CFG_RESET;
			done        <= 1'b0;
			hit         <= 1'b0;
			read_value  <= '0;
		end else begin
			done   <= 1'b0;
			val_s1 <= (state_q == ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (key_match) begin
				found_q <= 1'b1;
			end
			if (min_better) begin
				have_min_q <= 1'b1;
			end
			if (val_s1 && !valid_q[idx_s1]) begin
				have_free_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q     <= 1'b0;
						have_min_q  <= 1'b0;
						have_free_q <= 1'b0;
						cnt_q       <= '0;
						if (cap_eff == '0) begin
							// disabled cache: immediate miss, nothing changes
							done       <= 1'b1;
							hit        <= 1'b0;
							read_value <= '0;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_LAST;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q    <= ST_IDLE;
					done       <= 1'b1;
					hit        <= found_q;
					read_value <= (found_q && !act_q) ? match_val_q : '0;
					if (found_q || do_insert) begin
						tick_q <= tick_nx;
					end
					if (do_insert) begin
						valid_q[ins_slot] <= 1'b1;
						if (!use_victim) begin
							occ_q <= occ_q + OCC_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/lfu_chk.sv]
// Port-level checker for the LFU cache table, bound into lfu_cache_table_unit.
module lfu_chk
	import lfu_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             hit,
	input logic [VAL_W-1:0] read_value
);

	// a result word only shows while the sequencer is free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted command either starts a scan or answers at once
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted command went nowhere");

	// the end of a scan always delivers a word
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result");

	// misses carry a zero value; put hits read zero too but are not checked here
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (read_value == '0))
		else $error("miss with nonzero value");

endmodule

bind lfu_cache_table_unit lfu_chk u_lfu_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.read_value (read_value)
);

[verif/lfu_cache_table_unit_tb.sv]
// Self-checking testbench for lfu_cache_table_unit: directed and random cache traffic.
module lfu_cache_table_unit_tb;
	import lfu_pkg::*;

	localparam int CAPACITY = 16;
	// leave margin after the last reply before idle-only actions
	localparam int DRAIN    = CAPACITY + 8;
	// ~1550 items and their idle gaps, allowed for ~10x over
	localparam int LIMIT    = 400_000;

	typedef enum logic {ACT_GET = 1'b0, ACT_PUT = 1'b1} act_e;

	// one result word as the block returns it
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} reply_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             action = ACT_GET;
	logic [KEY_W-1:0] lookup_key = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             done;
	logic             hit;
	logic [VAL_W-1:0] read_value;

	always #1 clk = ~clk;

	lfu_cache_table_unit #(.CAPACITY(CAPACITY)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.hit        (hit),
		.read_value (read_value)
	);

	// ------------------------------------------------------------------
	// Shadow of the cache contents. Updated when a command word is taken,
	// so the queue below always holds the replies still on their way.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] capacity_setting = CFG_RESET;
	logic             shadow_valid[CAPACITY];
	logic [KEY_W-1:0] shadow_key[CAPACITY];
	logic [VAL_W-1:0] shadow_value[CAPACITY];
	count_t           shadow_count[CAPACITY];
	stamp_t           shadow_stamp[CAPACITY];
	stamp_t           shadow_tick = '0;
	int               shadow_occupancy = 0;

	reply_t replies_in_flight[$];
	int     error_count = 0;
	int     sender_idle_pct = 0;
	int     cycle_count = 0;

	initial begin
		for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;
	end

	// Bump use count (saturating) and restamp with the next tick (also saturating).
	function automatic void touch_slot(int s);
		if (shadow_count[s] != COUNT_MAX) shadow_count[s] = shadow_count[s] + 1'b1;
		if (shadow_tick != TICK_MAX) shadow_tick = shadow_tick + 1'b1;
		shadow_stamp[s] = shadow_tick;
	endfunction

	// Apply one access to the shadow and return the reply it must produce.
	function automatic reply_t predict_access(act_e act, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] val);
		reply_t r;
		int     eff;
		int     s;
		int     victim;
		r = '0;
		// register values above CAPACITY behave as CAPACITY
		eff = (capacity_setting > CAPACITY) ? CAPACITY : int'(capacity_setting);
		if (eff == 0) return r;
		s = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (s < 0 && shadow_valid[i] && shadow_key[i] == key) s = i;
		if (s >= 0) begin
			// hit: get returns the value, put overwrites it and reads back zero
			if (act == ACT_PUT) shadow_value[s] = val;
			else r.value = shadow_value[s];
			touch_slot(s);
			r.hit = 1'b1;
			return r;
		end
		if (act == ACT_GET) return r;
		// new key: evict min (count, stamp), lowest slot on full tie, if at/over capacity
		if (shadow_occupancy >= eff) begin
			victim = -1;
			for (int i = 0; i < CAPACITY; i++) begin
				if (!shadow_valid[i]) continue;
				if (victim < 0 || shadow_count[i] < shadow_count[victim] ||
						(shadow_count[i] == shadow_count[victim] &&
						 shadow_stamp[i] < shadow_stamp[victim]))
					victim = i;
			end
			if (victim >= 0) begin
				shadow_valid[victim] = 1'b0;
				shadow_occupancy--;
				s = victim;
			end
		end
		for (int i = 0; i < CAPACITY; i++)
			if (s < 0 && !shadow_valid[i]) s = i;
		if (s < 0) return r;
		shadow_valid[s] = 1'b1;
		shadow_key[s]   = key;
		shadow_value[s] = val;
		shadow_count[s] = count_t'(1);
		if (shadow_tick != TICK_MAX) shadow_tick = shadow_tick + 1'b1;
		shadow_stamp[s] = shadow_tick;
		shadow_occupancy++;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, sampled at the rising edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_replies
		reply_t want;
		if (done === 1'b1) begin
			if (replies_in_flight.size() == 0) begin
				$error("result word with none outstanding: hit %0d read_value %h",
					hit, read_value);
				error_count++;
			end else begin
				want = replies_in_flight.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					error_count++;
				end
				if (read_value !== want.value) begin
					$error("read_value: expected %h, got %h", want.value, read_value);
					error_count++;
				end
			end
		end
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("lfu_cache_table_unit_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driving helpers. Inputs change on the falling edge only.
	// ------------------------------------------------------------------

	// Present one command word; start may drop on any cycle per sender_idle_pct,
	// including while the block is busy. Returns at the edge that takes the word.
	task automatic send_word(act_e act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
		bit taken;
		taken = 1'b0;
		@(negedge clk);
		action      = act;
		lookup_key  = key;
		write_value = val;
		while (!taken) begin
			start = ($urandom_range(0, 99) >= sender_idle_pct);
			@(posedge clk);
			taken = start && !busy;
			if (!taken) @(negedge clk);
		end
		replies_in_flight.push_back(predict_access(act, key, val));
	endtask

	// Stop sending, wait for every outstanding reply, then let the sequencer settle.
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (replies_in_flight.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Capacity register write, only ever done with the block idle.
	task automatic write_capacity(logic [CFG_W-1:0] cap);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = cap;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		capacity_setting = cap;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes at reset capacity: keys and values all-zero / all-ones,
	// miss, insert, hit, and a put to a present key (hit with zero read data).
	task automatic test_field_extremes();
		send_word(ACT_GET, '0, '1);
		send_word(ACT_PUT, '0, '1);
		send_word(ACT_GET, '0, '0);
		send_word(ACT_PUT, '1, '0);
		send_word(ACT_PUT, '1, 32'h5A5A_A5A5);
		send_word(ACT_GET, '1, '0);
	endtask

	// LFU replacement with LRU tiebreak on a 3-entry cache.
	task automatic test_lfu_eviction();
		write_capacity(CFG_W'(3));
		send_word(ACT_PUT, 32'h0000_0A0A, 32'h1111_0001);
		send_word(ACT_PUT, 32'h0000_0B0B, 32'h1111_0002);
		send_word(ACT_PUT, 32'h0000_0C0C, 32'h1111_0003);
		send_word(ACT_GET, 32'h0000_0A0A, '0);
		send_word(ACT_GET, 32'h0000_0B0B, '0);
		send_word(ACT_PUT, 32'h0000_0D0D, 32'h1111_0004);  // lowest count goes
		send_word(ACT_GET, 32'h0000_0C0C, '0);
		send_word(ACT_GET, 32'h0000_0D0D, '0);             // ties with A and B on count
		send_word(ACT_PUT, 32'h0000_0E0E, 32'h1111_0005);  // older of the tie goes
		send_word(ACT_GET, 32'h0000_0B0B, '0);
		send_word(ACT_GET, 32'h0000_0D0D, '0);
	endtask

	// Capacity zero hides everything and drops puts; entries survive it.
	// 31 exceeds CAPACITY and must act as CAPACITY.
	task automatic test_capacity_zero();
		write_capacity('0);
		send_word(ACT_GET, 32'h0000_0A0A, '0);
		send_word(ACT_PUT, 32'h0000_0F0F, 32'h2222_0001);
		write_capacity('1);
		send_word(ACT_GET, 32'h0000_0F0F, '0);
		send_word(ACT_GET, 32'h0000_0A0A, '0);
	endtask

	// Shrinking below occupancy: a new key evicts exactly one entry.
	task automatic test_capacity_shrink();
		for (int i = 0; i < 4; i++) send_word(ACT_PUT, 32'h0000_1000 + i, $urandom);
		write_capacity(CFG_W'(2));
		send_word(ACT_PUT, 32'h0000_2000, $urandom);
		for (int i = 0; i < 4; i++) send_word(ACT_GET, 32'h0000_1000 + i, '0);
	endtask

	// One random phase: fixed capacity and sender idling, keys mostly drawn
	// from a small pool so hits, updates and evictions all happen often.
	task automatic run_random_phase(logic [CFG_W-1:0] cap, int idle_pct, int words,
			bit hold_off);
		logic [KEY_W-1:0] pool[24];
		int               pool_n;
		act_e             act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		write_capacity(cap);
		sender_idle_pct = idle_pct;
		pool_n = $urandom_range(2, 24);
		foreach (pool[i]) pool[i] = $urandom;
		if ($urandom_range(0, 1)) pool[0] = '0;
		if ($urandom_range(0, 1)) pool[1] = '1;
		for (int n = 0; n < words; n++) begin
			// sender waits out everything in flight once, mid-phase
			if (hold_off && n == words / 2) wait_idle();
			act = act_e'($urandom_range(0, 1));
			key = ($urandom_range(0, 99) < 90) ? pool[$urandom_range(0, pool_n - 1)]
			                                   : $urandom;
			case ($urandom_range(0, 9))
				0:       val = '0;
				1:       val = '1;
				default: val = $urandom;
			endcase
			send_word(act, key, val);
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(CFG_W'(16), 0,  160, 1'b0);
		run_random_phase(CFG_W'(1),  74, 160, 1'b1);
		run_random_phase(CFG_W'(31), 0,  160, 1'b0);
		run_random_phase(CFG_W'(3),  7,  160, 1'b0);
		run_random_phase(CFG_W'(0),  74, 30,  1'b0);
		run_random_phase(CFG_W'(8),  0,  160, 1'b1);
		run_random_phase(CFG_W'(2),  74, 160, 1'b0);
		run_random_phase(CFG_W'(17), 7,  160, 1'b0);
		run_random_phase(CFG_W'(5),  0,  160, 1'b0);
		run_random_phase(CFG_W'(15), 74, 160, 1'b0);
		run_random_phase(CFG_W'(16), 7,  50,  1'b0);
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_lfu_eviction();
		test_capacity_zero();
		test_capacity_shrink();
		test_random_traffic();

		wait_idle();
		if (error_count == 0)
			$display("lfu_cache_table_unit_tb OK");
		else
			$display("lfu_cache_table_unit_tb NOT OK");
		$finish;
	end

endmodule
